@@ sv/pdh_pkg.sv @@
package pdh_pkg;

  localparam int unsigned HDR_BYTES = 24;
  localparam int unsigned WIN_BYTES = 43;
  localparam int unsigned PAT_BYTES = 44;
  localparam int unsigned LEAD_NUM  = 6;

  localparam logic [31:0] CMD_OPEN = 32'h4e45504f;
  localparam logic [31:0] CMD_OKAY = 32'h59414b4f;
  localparam logic [31:0] CMD_CLSE = 32'h45534c43;
  localparam logic [31:0] CMD_WRTE = 32'h45545257;

  // match flag bits
  localparam int unsigned FLG_SHELL_LEAD = 4;
  localparam int unsigned FLG_FB_LEAD    = 5;
  localparam int unsigned FLG_RAW        = 6;

  // ":cat" of the battery capacity file, shared tail of the shell and raw
  // capacity queries, first char in the top byte
  localparam logic [311:0] CAP_PATH_TAIL =
    312'h3a636174_202f7379_732f636c_6173732f_706f7765_725f7375_70706c79_2f2a2f63_61706163_697479;

  // lead patterns, first char in the top byte, zero padded
  localparam logic [PAT_BYTES*8-1:0] LEAD_PAT [LEAD_NUM] = '{
    {"shell:exit", 272'h0},
    {"shell:getprop", 248'h0},
    {"shell", CAP_PATH_TAIL},
    {"framebuffer", 264'h0},
    {"shell", 312'h0},
    {"framebuffer", 264'h0}
  };
  localparam logic [5:0] LEAD_LEN [LEAD_NUM] = '{6'd10, 6'd13, 6'd44, 6'd11, 6'd5, 6'd11};

  // raw patterns, last char in the low byte
  localparam logic [71:0]  RAW_EXIT = ",raw:exit";
  localparam logic [95:0]  RAW_PROP = ",raw:getprop";
  localparam logic [343:0] RAW_CAP  = {",raw", CAP_PATH_TAIL};

  typedef struct packed {
    logic        emit;       // a result goes out
    logic        erase;      // drop a0 from the quiet set first
    logic        bad;        // header failed validation
    logic        quiet_open; // OPEN that qualifies as quiet
    logic [31:0] cmd;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] len;
  } pdh_op_t;

endpackage

@@ sv/pdh_front.sv @@
module pdh_front #(
  parameter int unsigned CAPTURE_BYTES = 1024,
  parameter int unsigned MAX_PAYLOAD   = 1048576
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            byte_vld,
  input  logic [7:0]      byte_dat,
  output logic            op_push,
  output pdh_pkg::pdh_op_t op_dat
);
  import pdh_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PAYLOAD + 1);

  logic                   track_en_r;
  logic                   halted_r, halted_nxt;
  logic                   in_pay_r, in_pay_nxt;
  logic [4:0]             hpos_r, hpos_nxt;
  logic [PW-1:0]          ppos_r, ppos_nxt;
  logic [HDR_BYTES*8-1:0] hdr_r, hdr_nxt;
  logic [WIN_BYTES*8-1:0] win_r, win_nxt;
  logic [6:0]             flg_r, flg_nxt;
  logic [31:0]            cmd, magic, len, cap;
  logic                   lead, exact, act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      track_en_r <= cfg_wr_data;
    end
  end

  always_comb begin
    halted_nxt = halted_r;
    in_pay_nxt = in_pay_r;
    hpos_nxt   = hpos_r;
    ppos_nxt   = ppos_r;
    hdr_nxt    = hdr_r;
    win_nxt    = win_r;
    flg_nxt    = flg_r;
    op_push    = 1'b0;
    act        = byte_vld && !halted_r && track_en_r;
    if (act && !in_pay_r) begin
      hdr_nxt = {byte_dat, hdr_r[HDR_BYTES*8-1:8]};
    end
    cmd   = hdr_nxt[31:0];
    len   = hdr_nxt[127:96];
    magic = hdr_nxt[191:160];
    op_dat.emit       = 1'b0;
    op_dat.erase      = 1'b0;
    op_dat.bad        = 1'b0;
    op_dat.quiet_open = 1'b0;
    op_dat.cmd        = cmd;
    op_dat.a0         = hdr_nxt[63:32];
    op_dat.a1         = hdr_nxt[95:64];
    op_dat.len        = len;
    if (act && !in_pay_r) begin
      if (hpos_r == 5'(HDR_BYTES - 1)) begin
        hpos_nxt = '0;
        if (cmd != ~magic || len > 32'(MAX_PAYLOAD)) begin
          halted_nxt  = 1'b1;
          op_push     = 1'b1;
          op_dat.emit = 1'b1;
          op_dat.bad  = 1'b1;
        end else begin
          op_dat.erase = (cmd == CMD_CLSE);
          flg_nxt      = 7'h3f;
          win_nxt      = '0;
          ppos_nxt     = '0;
          if (len == '0) begin
            op_push     = 1'b1;
            op_dat.emit = 1'b1;
          end else begin
            in_pay_nxt = 1'b1;
            op_push    = op_dat.erase;
          end
        end
      end else begin
        hpos_nxt = hpos_r + 5'd1;
      end
    end else if (act) begin
      if (32'(ppos_r) < 32'(CAPTURE_BYTES)) begin
        for (int k = 0; k < LEAD_NUM; k++) begin
          if (ppos_r < PW'(LEAD_LEN[k]) &&
              byte_dat != LEAD_PAT[k][PAT_BYTES*8-1-8*ppos_r[5:0] -: 8]) begin
            flg_nxt[k] = 1'b0;
          end
        end
        win_nxt = {win_r[WIN_BYTES*8-9:0], byte_dat};
        if (win_nxt[71:0] == RAW_EXIT || win_nxt[95:0] == RAW_PROP ||
            win_nxt[343:0] == RAW_CAP) begin
          flg_nxt[FLG_RAW] = 1'b1;
        end
      end
      ppos_nxt = ppos_r + PW'(1);
      if (32'(ppos_nxt) >= len) begin
        in_pay_nxt  = 1'b0;
        op_push     = 1'b1;
        op_dat.emit = 1'b1;
      end
    end
    // quiet shell rule on the finished payload
    cap   = (len < 32'(CAPTURE_BYTES)) ? len : 32'(CAPTURE_BYTES);
    lead  = (flg_nxt[FLG_SHELL_LEAD] && cap >= 32'(LEAD_LEN[FLG_SHELL_LEAD])) ||
            (flg_nxt[FLG_FB_LEAD] && cap >= 32'(LEAD_LEN[FLG_FB_LEAD]));
    exact = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (flg_nxt[k] && cap == 32'(LEAD_LEN[k])) exact = 1'b1;
    end
    op_dat.quiet_open = (cmd == CMD_OPEN) && in_pay_r && lead && (exact || flg_nxt[FLG_RAW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
      in_pay_r <= 1'b0;
      hpos_r   <= '0;
      ppos_r   <= '0;
      flg_r    <= '0;
      win_r    <= '0;
    end else begin
      halted_r <= halted_nxt;
      in_pay_r <= in_pay_nxt;
      hpos_r   <= hpos_nxt;
      ppos_r   <= ppos_nxt;
      flg_r    <= flg_nxt;
      win_r    <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

@@ sv/pdh_fifo.sv @@
module pdh_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pdh_pkg::pdh_op_t push_dat,
  input  logic             pop,
  output logic             not_empty,
  output logic             full,
  output pdh_pkg::pdh_op_t pop_dat
);
  import pdh_pkg::*;

  pdh_op_t    mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign not_empty = (cnt_r != 3'd0);
  assign full      = (cnt_r == 3'd4);
  assign pop_dat   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_dat;
  end

endmodule

@@ sv/pdh_back.sv @@
module pdh_back #(
  parameter int unsigned QUIET_ID_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_vld,
  input  pdh_pkg::pdh_op_t op_dat,
  output logic             op_pop,
  output logic             res_vld,
  input  logic             res_rdy,
  output logic [167:0]     res_dat
);
  import pdh_pkg::*;

  logic                  idv_r [QUIET_ID_ENTRIES];
  logic [31:0]           idval_r [QUIET_ID_ENTRIES];
  logic [31:0]           hb_cnt_r, hb_cnt_nxt;
  logic                  out_vld_r;
  logic [167:0]          out_r;
  logic                  member, free_found, quiet, hb, ovf, ins;
  logic [QUIET_ID_ENTRIES-1:0] hit, ins_sel;

  always_comb begin
    member     = 1'b0;
    free_found = 1'b0;
    ins_sel    = '0;
    for (int i = 0; i < QUIET_ID_ENTRIES; i++) begin
      hit[i] = idv_r[i] && idval_r[i] == op_dat.a0;
      if (hit[i]) member = 1'b1;
      if (!idv_r[i] && !free_found) begin
        free_found = 1'b1;
        ins_sel[i] = 1'b1;
      end
    end
    op_pop     = op_vld && (!op_dat.emit || !out_vld_r || res_rdy);
    ins        = op_dat.quiet_open && !member && free_found;
    ovf        = op_dat.quiet_open && !member && !free_found;
    quiet      = op_dat.quiet_open || (op_dat.cmd == CMD_WRTE && member);
    hb         = !op_dat.bad && op_dat.cmd != CMD_OKAY && op_dat.cmd != CMD_CLSE && !quiet;
    hb_cnt_nxt = hb_cnt_r + 32'(hb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUIET_ID_ENTRIES; i++) idv_r[i] <= 1'b0;
      hb_cnt_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= (op_pop && op_dat.emit) || (out_vld_r && !res_rdy);
      if (op_pop) begin
        for (int i = 0; i < QUIET_ID_ENTRIES; i++) begin
          if (op_dat.erase && hit[i]) idv_r[i] <= 1'b0;
          if (ins && ins_sel[i]) idv_r[i] <= 1'b1;
        end
        if (op_dat.emit) begin
          hb_cnt_r  <= hb_cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUIET_ID_ENTRIES; i++) begin
      if (op_pop && ins && ins_sel[i]) idval_r[i] <= op_dat.a0;
    end
    if (op_pop && op_dat.emit) begin
      out_r <= {5'd0, ovf, op_dat.bad, hb_cnt_nxt, hb,
                op_dat.len, op_dat.a1, op_dat.a0, op_dat.cmd};
    end
  end

  assign res_vld = out_vld_r;
  assign res_dat = out_r;

endmodule

@@ sv/packet_deframer_heartbeat.sv @@
// Message header sniffer with heartbeat counter.
// in_*: byte stream, one byte per word in in_tdata[7:0]; in_tready drops only
//   when the 4-entry op queue between front and back is full.
// out_*: one word per finished packet or bad header.
// cfg_*: track_enable; one parses, zero drops every byte. Write while idle.
// Throughput: one byte per cycle while the op queue has room. The front end
//   assembles the 24-byte header, checks it, walks the payload and matches
//   shell, framebuffer and raw strings; the back end owns the quiet ID set and
//   the heartbeat count.
// Ending byte to result word: queue write, then back end output register.
// Reset (rst_n low, synchronous): header parse restarts, count zero, ID set
//   empty, track_enable one. After a bad header the block drops bytes until
//   reset.
// Receiver stall: the output register holds, the queue fills, and in_tready
//   falls after four more ops; no word is lost.
module packet_deframer_heartbeat #(
  parameter int unsigned QUIET_ID_ENTRIES = 16,
  parameter int unsigned CAPTURE_BYTES    = 1024,
  parameter int unsigned MAX_PAYLOAD      = 1048576
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,   // track_enable
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,      // data_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] command_word, [63:32] first_arg, [95:64] second_arg,
  // [127:96] payload_length, [128] heartbeat, [160:129] heartbeat_total,
  // [161] bad_header, [162] set_overflow, [167:163] zero
  output logic [167:0] out_tdata
);
  import pdh_pkg::*;

  pdh_op_t fr_op, q_op;
  logic    fr_push, q_vld, q_full, q_pop;

  assign in_tready = !q_full;

  pdh_front #(
    .CAPTURE_BYTES (CAPTURE_BYTES),
    .MAX_PAYLOAD   (MAX_PAYLOAD)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_vld    (in_tvalid && in_tready),
    .byte_dat    (in_tdata),
    .op_push     (fr_push),
    .op_dat      (fr_op)
  );

  pdh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_push),
    .push_dat  (fr_op),
    .pop       (q_pop),
    .not_empty (q_vld),
    .full      (q_full),
    .pop_dat   (q_op)
  );

  pdh_back #(
    .QUIET_ID_ENTRIES (QUIET_ID_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_vld  (q_vld),
    .op_dat  (q_op),
    .op_pop  (q_pop),
    .res_vld (out_tvalid),
    .res_rdy (out_tready),
    .res_dat (out_tdata)
  );

endmodule

@@ sv/pdh_checker.sv @@
module pdh_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [167:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[161] |-> !out_tdata[128] && !out_tdata[162])
    else $error("bad header word carries heartbeat or overflow");

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[162] |-> !out_tdata[128])
    else $error("overflow word counted as heartbeat");

endmodule

bind packet_deframer_heartbeat pdh_checker u_pdh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
